// ----- rtl/core/lmse_pkg.sv -----
`default_nettype none

package lmse_pkg;

   // rgb to luma weights in unsigned q16, they sum to exactly 1.0
   localparam int unsigned WEIGHT_W = 16;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RED   = 16'd19595;
   localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN = 16'd38470;
   localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE  = 16'd7471;

   // pixel component and product widths
   localparam int unsigned PIXEL_W   = 8;
   localparam int unsigned PRODUCT_W = WEIGHT_W + PIXEL_W;
   localparam int unsigned SQUARE_W  = 2 * PIXEL_W;

   // result field widths
   localparam int unsigned SUM_OUT_W     = 36;
   localparam int unsigned COUNT_OUT_W   = 21;
   localparam int unsigned MSE_W         = 32;
   localparam int unsigned MSE_FRAC_BITS = 16;

endpackage : lmse_pkg

`default_nettype wire

// ----- rtl/core/luma_mse_accumulator.sv -----
`default_nettype none

// Luma mean squared error accumulator. Each pixel transfer carries a
// reference luma byte and an RGB triple; the triple is turned into luma with
// q16 weights and the squared difference, the mismatch count and the pixel
// count are accumulated. A pixel passes through the one shared 16x8
// multiplier (red, green and blue products, then the square) and then an
// accumulate step; once the frame holds 2^PIXEL_COUNT_BITS pixels further
// pixels are dropped and only set the overflow flag, though a last one still
// ends the frame. The last pixel of a frame starts the one-bit-per-cycle
// restoring divider that forms the q16 mean, after which the result is held
// in an output register and the block accepts the next frame while it waits.
module luma_mse_accumulator #(
   parameter int unsigned PIXEL_COUNT_BITS = 20
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // pixel channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [lmse_pkg::PIXEL_W-1:0]         req_ref_luma,
   input  wire logic [lmse_pkg::PIXEL_W-1:0]         req_red,
   input  wire logic [lmse_pkg::PIXEL_W-1:0]         req_green,
   input  wire logic [lmse_pkg::PIXEL_W-1:0]         req_blue,
   input  wire logic                                 req_last_pixel,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [lmse_pkg::SUM_OUT_W-1:0]            rsp_sum_squares,
   output logic [lmse_pkg::COUNT_OUT_W-1:0]          rsp_mismatch_count,
   output logic [lmse_pkg::COUNT_OUT_W-1:0]          rsp_pixels_seen,
   output logic [lmse_pkg::MSE_W-1:0]                rsp_mse_q16,
   output logic                                      rsp_overflow_flag
);

   import lmse_pkg::*;

   localparam int unsigned CNT_W = PIXEL_COUNT_BITS + 1;
   localparam int unsigned SUM_W = PIXEL_COUNT_BITS + SQUARE_W;
   localparam int unsigned DVD_W = SUM_W + MSE_FRAC_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_G,
      S_MUL_B,
      S_SQUARE,
      S_ACCUM,
      S_DIV_START,
      S_DIV_WAIT,
      S_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [PIXEL_W-1:0]     ref_ff, ref_in;
   logic [PIXEL_W-1:0]     green_ff, green_in;
   logic [PIXEL_W-1:0]     blue_ff, blue_in;
   logic                   last_ff, last_in;
   logic [PRODUCT_W-1:0]   luma_acc_ff, luma_acc_in;
   logic [SQUARE_W-1:0]    square_ff, square_in;
   logic [SUM_W-1:0]       sum_acc_ff, sum_acc_in;
   logic [CNT_W-1:0]       mismatch_ff, mismatch_in;
   logic [CNT_W-1:0]       pixel_ff, pixel_in;
   logic                   overflow_ff, overflow_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SUM_OUT_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic [COUNT_OUT_W-1:0] rsp_mismatch_ff, rsp_mismatch_in;
   logic [COUNT_OUT_W-1:0] rsp_pixels_ff, rsp_pixels_in;
   logic [MSE_W-1:0]       rsp_mse_ff, rsp_mse_in;
   logic                   rsp_overflow_ff, rsp_overflow_in;

   logic [WEIGHT_W-1:0]    mult_a;
   logic [PIXEL_W-1:0]     mult_b;
   logic [PRODUCT_W-1:0]   mult_out;
   logic [PIXEL_W-1:0]     luma;
   logic [PIXEL_W-1:0]     diff;
   logic                   saturated;
   logic                   out_free;

   logic                   div_start;
   logic                   div_done;
   logic [MSE_W-1:0]       div_quotient;

   // luma and its absolute difference to the reference
   assign luma      = luma_acc_ff[PRODUCT_W-1 -: PIXEL_W];
   assign diff      = (ref_ff >= luma) ? (ref_ff - luma) : (luma - ref_ff);
   assign saturated = pixel_ff[PIXEL_COUNT_BITS];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         S_IDLE: begin
            mult_a = WEIGHT_RED;
            mult_b = req_red;
         end
         S_MUL_G: begin
            mult_a = WEIGHT_GREEN;
            mult_b = green_ff;
         end
         S_MUL_B: begin
            mult_a = WEIGHT_BLUE;
            mult_b = blue_ff;
         end
         S_SQUARE: begin
            mult_a = WEIGHT_W'(diff);
            mult_b = diff;
         end
         default: begin
            mult_a = '0;
            mult_b = '0;
         end
      endcase
   end

   assign mult_out = PRODUCT_W'(mult_a) * PRODUCT_W'(mult_b);

   // sequencer
   always_comb begin
      state_in        = state_ff;
      ref_in          = ref_ff;
      green_in        = green_ff;
      blue_in         = blue_ff;
      last_in         = last_ff;
      luma_acc_in     = luma_acc_ff;
      square_in       = square_ff;
      sum_acc_in      = sum_acc_ff;
      mismatch_in     = mismatch_ff;
      pixel_in        = pixel_ff;
      overflow_in     = overflow_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_sum_in      = rsp_sum_ff;
      rsp_mismatch_in = rsp_mismatch_ff;
      rsp_pixels_in   = rsp_pixels_ff;
      rsp_mse_in      = rsp_mse_ff;
      rsp_overflow_in = rsp_overflow_ff;
      div_start       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ref_in      = req_ref_luma;
               green_in    = req_green;
               blue_in     = req_blue;
               last_in     = req_last_pixel;
               luma_acc_in = mult_out;
               if (saturated) begin
                  // frame too long: drop the pixel, flag it
                  overflow_in = 1'b1;
                  state_in    = req_last_pixel ? S_DIV_START : S_IDLE;
               end else begin
                  state_in = S_MUL_G;
               end
            end
         end
         S_MUL_G: begin
            luma_acc_in = luma_acc_ff + mult_out;
            state_in    = S_MUL_B;
         end
         S_MUL_B: begin
            luma_acc_in = luma_acc_ff + mult_out;
            state_in    = S_SQUARE;
         end
         S_SQUARE: begin
            square_in = mult_out[SQUARE_W-1:0];
            state_in  = S_ACCUM;
         end
         S_ACCUM: begin
            sum_acc_in  = sum_acc_ff + SUM_W'(square_ff);
            mismatch_in = mismatch_ff + CNT_W'(square_ff != '0);
            pixel_in    = pixel_ff + 1'b1;
            state_in    = last_ff ? S_DIV_START : S_IDLE;
         end
         S_DIV_START: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // load the result register and start a fresh frame
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_sum_in      = SUM_OUT_W'(sum_acc_ff);
               rsp_mismatch_in = COUNT_OUT_W'(mismatch_ff);
               rsp_pixels_in   = COUNT_OUT_W'(pixel_ff);
               rsp_mse_in      = div_quotient;
               rsp_overflow_in = overflow_ff;
               sum_acc_in      = '0;
               mismatch_in     = '0;
               pixel_in        = '0;
               overflow_in     = 1'b0;
               state_in        = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_acc_ff   <= '0;
         mismatch_ff  <= '0;
         pixel_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_acc_ff   <= sum_acc_in;
         mismatch_ff  <= mismatch_in;
         pixel_ff     <= pixel_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ref_ff          <= ref_in;
      green_ff        <= green_in;
      blue_ff         <= blue_in;
      last_ff         <= last_in;
      luma_acc_ff     <= luma_acc_in;
      square_ff       <= square_in;
      rsp_sum_ff      <= rsp_sum_in;
      rsp_mismatch_ff <= rsp_mismatch_in;
      rsp_pixels_ff   <= rsp_pixels_in;
      rsp_mse_ff      <= rsp_mse_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   // q16 mean: (sum << 16) / pixel count
   lmse_divider #(
      .DIVIDEND_W (DVD_W),
      .DIVISOR_W  (CNT_W),
      .QUOT_W     (MSE_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_acc_ff, MSE_FRAC_BITS'(0)}),
      .divisor  (pixel_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sum_squares    = rsp_sum_ff;
   assign rsp_mismatch_count = rsp_mismatch_ff;
   assign rsp_pixels_seen    = rsp_pixels_ff;
   assign rsp_mse_q16        = rsp_mse_ff;
   assign rsp_overflow_flag  = rsp_overflow_ff;

endmodule : luma_mse_accumulator

`default_nettype wire

// ----- rtl/core/lmse_divider.sv -----
`default_nettype none

module lmse_divider #(
   parameter int unsigned DIVIDEND_W = 52,
   parameter int unsigned DIVISOR_W  = 21,
   parameter int unsigned QUOT_W     = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [QUOT_W-1:0]          quotient
);

   localparam int unsigned STEP_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    trial_diff;
   logic                  fits;

   // one restoring step: shift in the next dividend bit, try a subtract
   assign trial      = {rem_ff, dvd_ff[DIVIDEND_W-1]};
   assign trial_diff = trial - {1'b0, divisor};
   assign fits       = (trial >= {1'b0, divisor});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVIDEND_W - 1);
         dvd_in  = dividend;
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         dvd_in  = {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule : lmse_divider

`default_nettype wire
